[rtl/matfc_pkg.sv]
// Package for the memory area table fault classifier.
// Types, constants and status codes shared by controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none
package matfc_pkg;
    localparam int AREA_COUNT = 16;
    localparam int PAGE_BYTES = 4096;
    localparam int IDX_W = $clog2(AREA_COUNT);
    localparam int CNT_W = $clog2(AREA_COUNT + 1);
    localparam int PAGE_W = $clog2(PAGE_BYTES);
    localparam logic [31:0] KERNEL_BASE = 32'hC000_0000;
    localparam int FLT_PRESENT = 0;
    localparam int FLT_WRITE = 1;
    localparam int FLT_IFETCH = 4;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_RESIZE = 2'd2,
        CMD_FAULT  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERLAP   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_INVALID   = 3'd3,
        ST_FAULT     = 3'd4,
        ST_FULL      = 3'd5,
        ST_KERNEL    = 3'd6
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture input word, clear scan index
        logic step;     // examine entry at scan index, advance
        logic shift;    // move entry idx+1 down to idx, advance
        logic append;   // write new entry at count
        logic resize;   // write new size at hit index
        logic dec;      // count - 1
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        cmd_t cmd;
        logic scan_done;  // scan index reached count
        logic hit;        // current entry matches (overlap / exact / contains)
        logic shift_done; // idx+1 reached count
        logic full;
        logic invalid;    // resize to empty
        status_t fault_st;// classification for a fault hit
    } dp_stat_t;

    function automatic logic [31:0] page_down(input logic [31:0] x);
        page_down = {x[31:PAGE_W], {PAGE_W{1'b0}}};
    endfunction

    function automatic logic [31:0] page_up(input logic [31:0] x);
        logic [31:0] t;
        t = x + 32'(PAGE_BYTES - 1);
        page_up = {t[31:PAGE_W], {PAGE_W{1'b0}}};
    endfunction
endpackage
`default_nettype wire

[rtl/matfc_datapath.sv]
// Datapath: area table registers, scan index, captured input word, compare logic.
// Depends on matfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module matfc_datapath
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire matfc_pkg::dp_cmd_t dcmd,
    output matfc_pkg::dp_stat_t    dstat,
    input  wire logic [1:0]        cmd,
    input  wire logic [31:0]       addr,
    input  wire logic [31:0]       length,
    input  wire logic [31:0]       new_length,
    input  wire logic              writable,
    input  wire logic [4:0]        fault_code
);
    import matfc_pkg::*;

    logic [31:0] base_mem [AREA_COUNT];
    logic [31:0] size_mem [AREA_COUNT];
    logic        wr_mem   [AREA_COUNT];

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [1:0]  cmd_reg;
    logic [31:0] addr_reg, begin_reg, end_reg, nend_reg;
    logic        wr_reg;
    logic [4:0]  code_reg;

    logic [IDX_W-1:0] ix, ix1;
    logic [31:0] e_base, e_size, e_top;
    logic        e_wr;
    logic [CNT_W-1:0] idx_p1;

    assign ix = idx_reg[IDX_W-1:0];
    assign idx_p1 = idx_reg + 1'b1;
    assign ix1 = idx_p1[IDX_W-1:0];
    assign e_base = base_mem[ix];
    assign e_size = size_mem[ix];
    assign e_wr = wr_mem[ix];
    assign e_top = e_base + e_size;

    always_comb
    begin
        dstat.cmd = cmd_t'(cmd_reg);
        dstat.scan_done = (idx_reg >= count_reg);
        dstat.shift_done = (idx_p1 >= count_reg);
        dstat.full = (count_reg >= CNT_W'(AREA_COUNT));
        dstat.invalid = (nend_reg == begin_reg);
        unique case (cmd_t'(cmd_reg))
            CMD_ADD:    dstat.hit = (e_top > begin_reg) && (e_base < end_reg);
            CMD_FAULT:  dstat.hit = (e_base <= addr_reg) && (addr_reg < e_top);
            default:    dstat.hit = (e_base == begin_reg) && (e_size == end_reg - begin_reg);
        endcase
        if (begin_reg >= KERNEL_BASE)
            dstat.fault_st = ST_KERNEL;
        else if (!code_reg[FLT_PRESENT])
            dstat.fault_st = ST_OK;
        else if (code_reg[FLT_IFETCH] || (code_reg[FLT_WRITE] && !e_wr))
            dstat.fault_st = ST_FAULT;
        else
            dstat.fault_st = ST_OK;
    end

    always_comb
    begin
        idx_next = idx_reg;
        count_next = count_reg;
        if (dcmd.load)
            idx_next = '0;
        else if (dcmd.step || dcmd.shift)
            idx_next = idx_p1;
        if (dcmd.append)
            count_next = count_reg + 1'b1;
        else if (dcmd.dec)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dcmd.load)
        begin
            cmd_reg <= cmd;
            addr_reg <= addr;
            begin_reg <= page_down(addr);
            end_reg <= page_up(addr + length);
            nend_reg <= page_up(addr + new_length);
            wr_reg <= writable;
            code_reg <= fault_code;
        end
        if (dcmd.append)
        begin
            base_mem[count_reg[IDX_W-1:0]] <= begin_reg;
            size_mem[count_reg[IDX_W-1:0]] <= end_reg - begin_reg;
            wr_mem[count_reg[IDX_W-1:0]] <= wr_reg;
        end
        if (dcmd.shift)
        begin
            base_mem[ix] <= base_mem[ix1];
            size_mem[ix] <= size_mem[ix1];
            wr_mem[ix] <= wr_mem[ix1];
        end
        if (dcmd.resize)
            size_mem[ix] <= nend_reg - begin_reg;
    end

    property p_count_range;
        @(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(AREA_COUNT);
    endproperty
    a_count_range: assert property (p_count_range) else $error("area count above table depth");
    property p_append_room;
        @(posedge clk) disable iff (!rst_n) dcmd.append |-> count_reg < CNT_W'(AREA_COUNT);
    endproperty
    a_append_room: assert property (p_append_room) else $error("append into full table");
    property p_dec_nonzero;
        @(posedge clk) disable iff (!rst_n) dcmd.dec |-> count_reg != '0;
    endproperty
    a_dec_nonzero: assert property (p_dec_nonzero) else $error("decrement of empty table");
endmodule
`default_nettype wire

[rtl/matfc_ctrl.sv]
// Controller state machine: sequences scan, update, compaction and result word.
// Depends on matfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module matfc_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [2:0]               status,
    output matfc_pkg::dp_cmd_t       dcmd,
    input  wire matfc_pkg::dp_stat_t dstat
);
    import matfc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_SHIFT = 3'b100
    } state_t;

    state_t  state_reg, state_next;
    logic    ov_reg, ov_next;
    status_t st_reg, st_next;
    logic    done;
    status_t res;

    assign in_ready = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign status = st_reg;

    always_comb
    begin
        state_next = state_reg;
        dcmd = '0;
        done = 1'b0;
        res = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    dcmd.load = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (dstat.cmd == CMD_RESIZE && dstat.invalid)
                begin
                    done = 1'b1; res = ST_INVALID;
                end
                else if (dstat.scan_done)
                begin
                    done = 1'b1;
                    priority case (1'b1)
                        dstat.cmd == CMD_ADD && dstat.full: res = ST_FULL;
                        dstat.cmd == CMD_ADD: begin res = ST_OK; dcmd.append = 1'b1; end
                        default: res = ST_NOT_FOUND;
                    endcase
                end
                else if (dstat.hit)
                begin
                    unique case (dstat.cmd)
                        CMD_ADD: begin done = 1'b1; res = ST_OVERLAP; end
                        CMD_FAULT: begin done = 1'b1; res = dstat.fault_st; end
                        CMD_RESIZE: begin done = 1'b1; dcmd.resize = 1'b1; end
                        CMD_REMOVE: state_next = S_SHIFT;
                    endcase
                end
                else
                    dcmd.step = 1'b1;
                if (done)
                    state_next = S_IDLE;
            end
            S_SHIFT:
            begin
                if (dstat.shift_done)
                begin
                    dcmd.dec = 1'b1;
                    done = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    dcmd.shift = 1'b1;
            end
            default: state_next = S_IDLE;
        endcase
        ov_next = ov_reg;
        st_next = st_reg;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        if (done)
        begin
            ov_next = 1'b1;
            st_next = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
            st_reg <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
            st_reg <= st_next;
        end
    end

    property p_one_op;
        @(posedge clk) disable iff (!rst_n) $onehot0({dcmd.load, dcmd.step, dcmd.shift,
            dcmd.append, dcmd.resize, dcmd.dec});
    endproperty
    a_one_op: assert property (p_one_op) else $error("conflicting datapath commands");
    property p_busy_no_out;
        @(posedge clk) disable iff (!rst_n) (state_reg != S_IDLE) |-> !ov_reg;
    endproperty
    a_busy_no_out: assert property (p_busy_no_out) else $error("result word while busy");
    property p_accept_start;
        @(posedge clk) disable iff (!rst_n) (in_valid && in_ready) |=> state_reg == S_SCAN;
    endproperty
    a_accept_start: assert property (p_accept_start) else $error("accepted word not scanned");
endmodule
`default_nettype wire

[rtl/memory_area_table_fault_classifier_core.sv]
// Top level of the memory area table fault classifier.
// Depends on matfc_pkg, matfc_ctrl and matfc_datapath.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   Input channel (in_valid/in_ready) carries one command word: cmd, addr,
//   length, new_length, writable, fault_code. Output channel
//   (out_valid/out_ready) carries one status word per command.
//   The table holds up to 16 page-aligned areas in insertion order.
//   The word is captured at the accepting edge, then the scan examines the
//   entries in order and then sees the end of the table; the status word is
//   registered at the last scan or shift edge. Remove stops the scan at the
//   hit and moves the rest down one per cycle, then decrements the count.
//   in_ready returns the cycle after the status word is taken. The single
//   scan port on the entry registers sets the processing time; one word is
//   processed at a time.
//   Reset clears the entry count and the controller; table contents are
//   never read before written, so no clearing pass is needed.
//   If the receiver stalls, the status word holds in the output register
//   and no new word is accepted until it is taken.
module memory_area_table_fault_classifier_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  cmd,
    input  wire logic [31:0] addr,
    input  wire logic [31:0] length,
    input  wire logic [31:0] new_length,
    input  wire logic        writable,
    input  wire logic [4:0]  fault_code,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status
);
    import matfc_pkg::*;

    dp_cmd_t  dcmd;
    dp_stat_t dstat;

    matfc_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .dcmd(dcmd), .dstat(dstat)
    );

    matfc_datapath u_dp
    (
        .clk(clk), .rst_n(rst_n), .dcmd(dcmd), .dstat(dstat),
        .cmd(cmd), .addr(addr), .length(length), .new_length(new_length),
        .writable(writable), .fault_code(fault_code)
    );
endmodule
`default_nettype wire

[tb/matfc_checker.sv]
// Checker for the memory area table fault classifier: watches both channels,
// predicts each status word from its own copy of the area table and compares.
// Depends on matfc_pkg.
`timescale 1ns / 1ps
module matfc_checker
    import matfc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [1:0]  cmd,
    input  wire logic [31:0] addr,
    input  wire logic [31:0] length,
    input  wire logic [31:0] new_length,
    input  wire logic        writable,
    input  wire logic [4:0]  fault_code,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [2:0]  status,
    output int               fail_count,
    output int               pending
);
    logic [31:0] tbl_base [AREA_COUNT];
    logic [31:0] tbl_size [AREA_COUNT];
    logic        tbl_wr [AREA_COUNT];
    int          tbl_n;
    status_t     status_q [$];

    function automatic logic [31:0] pg_dn(logic [31:0] x);
        return x & ~32'(PAGE_BYTES - 1);
    endfunction

    function automatic logic [31:0] pg_up(logic [31:0] x);
        return pg_dn(x + 32'(PAGE_BYTES - 1));
    endfunction

    function automatic int find_area(logic [31:0] b, logic [31:0] s);
        for (int i = 0; i < tbl_n; i++)
            if (tbl_base[i] == b && tbl_size[i] == s)
                return i;
        return -1;
    endfunction

    // Applies one command word to the table copy, returns its status.
    function automatic status_t classify_word(cmd_t c, logic [31:0] a, logic [31:0] len,
                                             logic [31:0] nlen, logic w,
                                             logic [4:0] code);
        logic [31:0] b;
        logic [31:0] e;
        logic [31:0] ne;
        int          k;
        b = pg_dn(a);
        e = pg_up(a + len);
        case (c)
            CMD_ADD:
            begin
                for (int i = 0; i < tbl_n; i++)
                    if (tbl_base[i] + tbl_size[i] > b && tbl_base[i] < e)
                        return ST_OVERLAP;
                if (tbl_n >= AREA_COUNT)
                    return ST_FULL;
                tbl_base[tbl_n] = b;
                tbl_size[tbl_n] = e - b;
                tbl_wr[tbl_n] = w;
                tbl_n++;
                return ST_OK;
            end
            CMD_REMOVE:
            begin
                k = find_area(b, e - b);
                if (k < 0)
                    return ST_NOT_FOUND;
                for (int i = k; i + 1 < tbl_n; i++)
                begin
                    tbl_base[i] = tbl_base[i + 1];
                    tbl_size[i] = tbl_size[i + 1];
                    tbl_wr[i] = tbl_wr[i + 1];
                end
                tbl_n--;
                return ST_OK;
            end
            CMD_RESIZE:
            begin
                ne = pg_up(a + nlen);
                if (ne == b)
                    return ST_INVALID;
                k = find_area(b, e - b);
                if (k < 0)
                    return ST_NOT_FOUND;
                tbl_size[k] = ne - b;
                return ST_OK;
            end
            default:
            begin
                k = -1;
                for (int i = 0; i < tbl_n; i++)
                    if (k < 0 && tbl_base[i] <= a && a < tbl_base[i] + tbl_size[i])
                        k = i;
                if (k < 0)
                    return ST_NOT_FOUND;
                if (pg_dn(a) >= KERNEL_BASE)
                    return ST_KERNEL;
                if (!code[FLT_PRESENT])
                    return ST_OK;
                if (code[FLT_IFETCH])
                    return ST_FAULT;
                if (code[FLT_WRITE] && !tbl_wr[k])
                    return ST_FAULT;
                return ST_OK;
            end
        endcase
    endfunction

    assign pending = status_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_n <= 0;
            fail_count <= 0;
            status_q.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (status_q.size() == 0)
                begin
                    $error("status word with none expected: %0d", status);
                    fail_count <= fail_count + 1;
                end
                else if (status !== status_q[0])
                begin
                    $error("status expected %0d actual %0d", status_q[0], status);
                    fail_count <= fail_count + 1;
                    void'(status_q.pop_front());
                end
                else
                    void'(status_q.pop_front());
            end
            if (in_valid && in_ready)
                status_q.push_back(classify_word(cmd_t'(cmd), addr, length, new_length,
                                                 writable, fault_code));
        end
    end
endmodule

[tb/memory_area_table_fault_classifier_core_tb.sv]
// Testbench top for the memory area table fault classifier core.
// Drives command words with random idling; matfc_checker does the checking.
// Depends on matfc_pkg, matfc_checker and the core.
`timescale 1ns / 1ps
module memory_area_table_fault_classifier_core_tb;
    import matfc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  cmd;
    logic [31:0] addr;
    logic [31:0] length;
    logic [31:0] new_length;
    logic        writable;
    logic [4:0]  fault_code;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    int          fail_count;
    int          pending;
    bit          calm;      // end of run: no idling on either side

    // Areas this run has added; used to aim removes, resizes and faults.
    logic [31:0] live_addr [$];
    logic [31:0] live_len [$];

    memory_area_table_fault_classifier_core u_top (.*);

    matfc_checker u_chk (.*);

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random bursts of stall and of readiness.
    initial
    begin
        int n;
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            n = $urandom_range(1, 17);
            out_ready <= calm || $urandom_range(0, 2) != 0;
            repeat (n) @(posedge clk);
        end
    end

    // Presents one word and holds it until accepted. Valid stays high after
    // acceptance so back-to-back words need no second drive in one step;
    // it drops only for an idle burst or at the end of a sequence.
    task automatic send_word(cmd_t c, logic [31:0] a, logic [31:0] len,
                             logic [31:0] nlen, logic w, logic [4:0] code);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1;
        cmd <= c;
        addr <= a;
        length <= len;
        new_length <= nlen;
        writable <= w;
        fault_code <= code;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Well-formed traffic mostly: areas in a small window so overlaps, hits
    // and exact matches are common; the rest is fully random noise.
    task automatic random_word();
        logic [31:0] a;
        logic [31:0] len;
        int          k;
        int          pick;
        pick = $urandom_range(0, 99);
        a = {$urandom_range(0, 3) == 0 ? 4'hC : 4'h4, 8'h00,
             4'($urandom_range(0, 15)), 4'h0, 12'($urandom)};
        len = 32'($urandom_range(0, 5 * PAGE_BYTES));
        k = live_addr.size() ? $urandom_range(0, live_addr.size() - 1) : 0;
        if (pick < 10)
            send_word(cmd_t'($urandom), $urandom, $urandom, $urandom, $urandom,
                      5'($urandom));
        else if (pick < 40 || live_addr.size() == 0)
        begin
            send_word(CMD_ADD, a, len, $urandom, $urandom, 5'($urandom));
            live_addr.push_back(a);
            live_len.push_back(len);
        end
        else if (pick < 55)
        begin
            send_word(CMD_REMOVE, live_addr[k], live_len[k], $urandom, $urandom,
                      5'($urandom));
            live_addr.delete(k);
            live_len.delete(k);
        end
        else if (pick < 65)
        begin
            len = 32'($urandom_range(0, 4 * PAGE_BYTES));
            send_word(CMD_RESIZE, live_addr[k], live_len[k], len, $urandom,
                      5'($urandom));
            live_len[k] = len;
        end
        else
            send_word(CMD_FAULT, live_addr[k] + 32'($urandom_range(0, 3 * PAGE_BYTES)),
                      $urandom, $urandom, $urandom, 5'($urandom));
    endtask

    initial
    begin
        in_valid = 0;
        cmd = CMD_ADD;
        addr = 0;
        length = 0;
        new_length = 0;
        writable = 0;
        fault_code = 0;
        calm = 0;
        rst_n = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: empty table, extremes, every command and fault class.
        send_word(CMD_FAULT, 32'h1000, 0, 0, 0, 5'h1F);
        send_word(CMD_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
        send_word(CMD_ADD, 32'h0000_1000, 32'h2000, 0, 1, 0);
        send_word(CMD_ADD, 32'h0000_2FFF, 32'h10, 0, 0, 0);
        send_word(CMD_ADD, 32'h0000_5000, 0, 0, 0, 0);
        send_word(CMD_ADD, 32'h0000_5000, 0, 0, 0, 0);
        send_word(CMD_ADD, 32'hFFFF_F000, 32'h0000_2000, 0, 1, 0);
        send_word(CMD_ADD, 32'hC000_0000, 32'h1000, 0, 1, 0);
        send_word(CMD_ADD, 32'h0001_0000, 32'h1000, 0, 0, 0);
        send_word(CMD_FAULT, 32'hC000_0FFF, 0, 0, 0, 5'h00);
        send_word(CMD_FAULT, 32'h0000_1800, 0, 0, 0, 5'h00);
        send_word(CMD_FAULT, 32'h0000_1800, 0, 0, 0, 5'h11);
        send_word(CMD_FAULT, 32'h0000_1800, 0, 0, 0, 5'h0F);
        send_word(CMD_FAULT, 32'h0001_0010, 0, 0, 0, 5'h03);
        send_word(CMD_FAULT, 32'h0001_0010, 0, 0, 0, 5'h05);
        send_word(CMD_RESIZE, 32'h0001_0000, 32'h1000, 0, 0, 0);
        send_word(CMD_RESIZE, 32'h0001_0000, 32'h1000, 32'hFFFF_FFFF, 0, 0);
        send_word(CMD_RESIZE, 32'h0002_0000, 32'h1000, 32'h1000, 0, 0);
        send_word(CMD_REMOVE, 32'h0000_1000, 32'h2000, 0, 0, 0);
        send_word(CMD_REMOVE, 32'h0000_1000, 32'h2000, 0, 0, 0);
        for (int i = 0; i < 14; i++)
            send_word(CMD_ADD, 32'h0100_0000 + 32'(i) * 32'h10000, 32'h1000, 0, i[0], 0);
        in_valid <= 0;

        // Hold off until the table is quiet, then remove from the full table the areas added above.
        wait (pending == 0);
        for (int i = 0; i < 14; i++)
            send_word(CMD_REMOVE, 32'h0100_0000 + 32'(i) * 32'h10000, 32'h1000, 0, 0, 0);

        for (int i = 0; i < 1280; i++)
        begin
            if (i == 1180)
                calm = 1;
            random_word();
        end
        in_valid <= 0;

        wait (pending == 0);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

[files.f]
rtl/matfc_pkg.sv
rtl/matfc_datapath.sv
rtl/matfc_ctrl.sv
rtl/memory_area_table_fault_classifier_core.sv
tb/matfc_checker.sv
tb/memory_area_table_fault_classifier_core_tb.sv
